// File: hw/rtl/tcpq_pkg.sv
// Shared constants, types and address helper for the three-class priority queue.
package tcpq_pkg;

   localparam int CLASS_DEPTH = 16;
   localparam int HANDLE_BITS = 16;
   localparam int NUM_CLASSES = 3;

   localparam int ACTION_W = 2;
   localparam int TYPE_W = 8;
   localparam int HANDLE_W = 16;
   localparam int CLASS_W = 2;

   localparam int STORE_BITS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
   localparam int PTR_BITS = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(CLASS_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;
   localparam int ADDR_BITS = $clog2(STORE_DEPTH);

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [CLASS_W-1:0] cls_type;
   typedef logic [PTR_BITS-1:0] ptr_type;
   typedef logic [CNT_BITS-1:0] cnt_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [STORE_BITS-1:0] data_type;

   localparam action_type ACT_PUSH = 2'd0;
   localparam action_type ACT_POP = 2'd1;
   localparam action_type ACT_PEEK = 2'd2;

   localparam cls_type CLS_HIGH = 2'd0;
   localparam cls_type CLS_MID = 2'd1;
   localparam cls_type CLS_LOW = 2'd2;

   localparam logic [TYPE_W-1:0] TYPE_LOW = 8'd0;
   localparam logic [TYPE_W-1:0] TYPE_MID = 8'd1;

   typedef struct packed {
      logic    serve;
      cls_type cls;
      logic    empty_error;
      logic    full_drop;
      logic    now_empty;
   } result_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

   function automatic addr_type class_addr(cls_type cls, ptr_type ptr);
      return addr_type'(addr_type'(cls) * addr_type'(CLASS_DEPTH) + addr_type'(ptr));
   endfunction

   function automatic ptr_type ptr_advance(ptr_type ptr);
      return (ptr == ptr_type'(CLASS_DEPTH - 1)) ? '0 : ptr_type'(ptr + 1'b1);
   endfunction

endpackage

// File: hw/rtl/tcpq_store.sv
// Handle memory for all three classes, one write port and one registered read port.
module tcpq_store (
   input  logic                  clock,
   input  tcpq_pkg::mem_req_type mem_req,
   output tcpq_pkg::data_type    rd_data
);

   tcpq_pkg::data_type mem [tcpq_pkg::STORE_DEPTH];
   tcpq_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tcpq_ctrl.sv
// Class pointers, occupancy counts and the push, pop and peek decisions.
module tcpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  tcpq_pkg::action_type    in_action,
   input  logic [tcpq_pkg::TYPE_W-1:0] in_type,
   input  logic [tcpq_pkg::HANDLE_W-1:0] in_handle,
   output tcpq_pkg::result_type    result,
   output tcpq_pkg::mem_req_type   mem_req
);

   tcpq_pkg::ptr_type head_ff [tcpq_pkg::NUM_CLASSES];
   tcpq_pkg::ptr_type tail_ff [tcpq_pkg::NUM_CLASSES];
   tcpq_pkg::cnt_type count_ff [tcpq_pkg::NUM_CLASSES];
   tcpq_pkg::ptr_type head_in [tcpq_pkg::NUM_CLASSES];
   tcpq_pkg::ptr_type tail_in [tcpq_pkg::NUM_CLASSES];
   tcpq_pkg::cnt_type count_in [tcpq_pkg::NUM_CLASSES];

   logic [tcpq_pkg::NUM_CLASSES-1:0] nonempty;
   logic [tcpq_pkg::NUM_CLASSES-1:0] full;
   logic [tcpq_pkg::NUM_CLASSES-1:0] push_en;
   logic [tcpq_pkg::NUM_CLASSES-1:0] pop_en;
   logic                 is_push;
   logic                 is_read;
   logic                 any;
   logic                 push_full;
   logic                 all_empty_in;
   tcpq_pkg::cls_type    push_cls;
   tcpq_pkg::cls_type    srv_cls;
   tcpq_pkg::ptr_type    head_sel;
   tcpq_pkg::ptr_type    tail_sel;

   always_comb begin
      is_push = in_vld && (in_action == tcpq_pkg::ACT_PUSH);
      is_read = in_vld && ((in_action == tcpq_pkg::ACT_POP) ||
                           (in_action == tcpq_pkg::ACT_PEEK));
      if (in_type == tcpq_pkg::TYPE_LOW) begin
         push_cls = tcpq_pkg::CLS_LOW;
      end else if (in_type == tcpq_pkg::TYPE_MID) begin
         push_cls = tcpq_pkg::CLS_MID;
      end else begin
         push_cls = tcpq_pkg::CLS_HIGH;
      end
      for (int i = 0; i < tcpq_pkg::NUM_CLASSES; i++) begin
         nonempty[i] = (count_ff[i] != '0);
         full[i] = (count_ff[i] == tcpq_pkg::cnt_type'(tcpq_pkg::CLASS_DEPTH));
      end
      any = |nonempty;
      priority if (nonempty[tcpq_pkg::CLS_HIGH]) begin
         srv_cls = tcpq_pkg::CLS_HIGH;
      end else if (nonempty[tcpq_pkg::CLS_MID]) begin
         srv_cls = tcpq_pkg::CLS_MID;
      end else begin
         srv_cls = tcpq_pkg::CLS_LOW;
      end
      push_full = 1'b0;
      head_sel = '0;
      tail_sel = '0;
      all_empty_in = 1'b1;
      for (int i = 0; i < tcpq_pkg::NUM_CLASSES; i++) begin
         if (push_cls == tcpq_pkg::cls_type'(i)) begin
            push_full = full[i];
            tail_sel = tail_ff[i];
         end
         if (srv_cls == tcpq_pkg::cls_type'(i)) begin
            head_sel = head_ff[i];
         end
         push_en[i] = is_push && (push_cls == tcpq_pkg::cls_type'(i)) && !full[i];
         pop_en[i] = is_read && (in_action == tcpq_pkg::ACT_POP) && any &&
                     (srv_cls == tcpq_pkg::cls_type'(i));
         head_in[i] = pop_en[i] ? tcpq_pkg::ptr_advance(head_ff[i]) : head_ff[i];
         tail_in[i] = push_en[i] ? tcpq_pkg::ptr_advance(tail_ff[i]) : tail_ff[i];
         if (push_en[i]) begin
            count_in[i] = tcpq_pkg::cnt_type'(count_ff[i] + 1'b1);
         end else if (pop_en[i]) begin
            count_in[i] = tcpq_pkg::cnt_type'(count_ff[i] - 1'b1);
         end else begin
            count_in[i] = count_ff[i];
         end
         if (count_in[i] != '0) begin
            all_empty_in = 1'b0;
         end
      end

      result.serve = is_read && any;
      result.empty_error = is_read && !any;
      result.full_drop = is_push && push_full;
      result.now_empty = all_empty_in;
      if (is_push) begin
         result.cls = push_cls;
      end else if (is_read && any) begin
         result.cls = srv_cls;
      end else begin
         result.cls = tcpq_pkg::CLS_HIGH;
      end

      mem_req.wr_en = |push_en;
      mem_req.wr_addr = tcpq_pkg::class_addr(push_cls, tail_sel);
      mem_req.wr_data = in_handle[tcpq_pkg::STORE_BITS-1:0];
      mem_req.rd_en = is_read && any;
      mem_req.rd_addr = tcpq_pkg::class_addr(srv_cls, head_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tcpq_pkg::NUM_CLASSES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < tcpq_pkg::NUM_CLASSES; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   for (genvar g = 0; g < tcpq_pkg::NUM_CLASSES; g++) begin : g_check
      a_count_range: assert property (@(posedge clock) disable iff (reset)
         int'(count_ff[g]) <= tcpq_pkg::CLASS_DEPTH)
         else $error("Class occupancy exceeds its depth.");

      a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
         ((int'(head_ff[g]) + int'(count_ff[g]) >= tcpq_pkg::CLASS_DEPTH) ?
          (int'(head_ff[g]) + int'(count_ff[g]) - tcpq_pkg::CLASS_DEPTH) :
          (int'(head_ff[g]) + int'(count_ff[g]))) == int'(tail_ff[g]))
         else $error("Head, tail and occupancy of a class disagree.");

      a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
         pop_en[g] |=> (int'(count_ff[g]) == int'($past(count_ff[g])) - 1))
         else $error("A pop did not reduce the class occupancy.");
   end

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !((|push_en) && (|pop_en)))
      else $error("A push and a pop were carried out together.");

endmodule

// File: hw/rtl/three_class_priority_queue_unit.sv
// Top level of the three-class strict-priority queue.
//
//  Channel   Ports                                    Handshake
//  request   req_action, req_entry_type,              start high while busy low
//            req_entry_handle
//  response  rsp_out_handle, rsp_out_class,           rsp_strobe high for one cycle
//            rsp_empty_error, rsp_full_drop, rsp_now_empty
//
// A new word is taken in every cycle; each word's response passes through the input
// register, the registered read of the handle memory and the response register before
// it reaches the ports.
// Busy is high during reset and in the cycle after it, and low from then on.
// The response channel has no back-pressure, so nothing ever stalls the pipeline.
module three_class_priority_queue_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [tcpq_pkg::ACTION_W-1:0]         req_action,
   input  logic [tcpq_pkg::TYPE_W-1:0]           req_entry_type,
   input  logic [tcpq_pkg::HANDLE_W-1:0]         req_entry_handle,
   output logic                                  rsp_strobe,
   output logic [tcpq_pkg::HANDLE_W-1:0]         rsp_out_handle,
   output logic [tcpq_pkg::CLASS_W-1:0]          rsp_out_class,
   output logic                                  rsp_empty_error,
   output logic                                  rsp_full_drop,
   output logic                                  rsp_now_empty
);

   logic                                 busy_ff;
   logic                                 in_vld_ff;
   tcpq_pkg::action_type                 in_action_ff;
   logic [tcpq_pkg::TYPE_W-1:0]          in_type_ff;
   logic [tcpq_pkg::HANDLE_W-1:0]        in_handle_ff;
   logic                                 s2_vld_ff;
   tcpq_pkg::result_type                 s2_res_ff;
   logic                                 rsp_strobe_ff;
   logic [tcpq_pkg::HANDLE_W-1:0]        rsp_handle_ff;
   tcpq_pkg::cls_type                    rsp_class_ff;
   logic                                 rsp_err_ff;
   logic                                 rsp_drop_ff;
   logic                                 rsp_empty_ff;
   tcpq_pkg::result_type                 res;
   tcpq_pkg::mem_req_type                mem_req;
   tcpq_pkg::data_type                   rd_data;
   logic                                 accept;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         in_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         in_vld_ff <= accept;
         s2_vld_ff <= in_vld_ff;
         rsp_strobe_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff <= req_action;
         in_type_ff <= req_entry_type;
         in_handle_ff <= req_entry_handle;
      end
      if (in_vld_ff) begin
         s2_res_ff <= res;
      end
      if (s2_vld_ff) begin
         rsp_handle_ff <= s2_res_ff.serve ? tcpq_pkg::HANDLE_W'(rd_data) : '0;
         rsp_class_ff <= s2_res_ff.cls;
         rsp_err_ff <= s2_res_ff.empty_error;
         rsp_drop_ff <= s2_res_ff.full_drop;
         rsp_empty_ff <= s2_res_ff.now_empty;
      end
   end

   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (in_vld_ff),
      .in_action (in_action_ff),
      .in_type   (in_type_ff),
      .in_handle (in_handle_ff),
      .result    (res),
      .mem_req   (mem_req)
   );

   tcpq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign busy = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_class = rsp_class_ff;
   assign rsp_empty_error = rsp_err_ff;
   assign rsp_full_drop = rsp_drop_ff;
   assign rsp_now_empty = rsp_empty_ff;

endmodule

// File: verif/tcpq_checker.sv
// Checker that predicts each response of the three-class priority queue and compares it.
module tcpq_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [tcpq_pkg::ACTION_W-1:0] req_action,
   input  logic [tcpq_pkg::TYPE_W-1:0]   req_entry_type,
   input  logic [tcpq_pkg::HANDLE_W-1:0] req_entry_handle,
   input  logic                          rsp_strobe,
   input  logic [tcpq_pkg::HANDLE_W-1:0] rsp_out_handle,
   input  logic [tcpq_pkg::CLASS_W-1:0]  rsp_out_class,
   input  logic                          rsp_empty_error,
   input  logic                          rsp_full_drop,
   input  logic                          rsp_now_empty,
   output int                            fail_count,
   output int                            outstanding
);

   localparam int PEND_BITS = 3;
   localparam int PEND_DEPTH = 1 << PEND_BITS;

   typedef struct packed {
      logic [tcpq_pkg::HANDLE_W-1:0] handle;
      tcpq_pkg::cls_type             cls;
      logic                          empty_error;
      logic                          full_drop;
      logic                          now_empty;
   } outcome_type;

   tcpq_pkg::data_type slot [tcpq_pkg::NUM_CLASSES][tcpq_pkg::CLASS_DEPTH];
   tcpq_pkg::ptr_type  rd_ptr [tcpq_pkg::NUM_CLASSES];
   tcpq_pkg::ptr_type  wr_ptr [tcpq_pkg::NUM_CLASSES];
   tcpq_pkg::cnt_type  fill [tcpq_pkg::NUM_CLASSES];
   outcome_type        pending [PEND_DEPTH];
   logic [PEND_BITS-1:0] pend_rd;
   logic [PEND_BITS-1:0] pend_wr;
   int                 pend_count;

   function automatic tcpq_pkg::ptr_type next_slot(tcpq_pkg::ptr_type p);
      return (p == tcpq_pkg::ptr_type'(tcpq_pkg::CLASS_DEPTH - 1)) ?
             tcpq_pkg::ptr_type'(0) : tcpq_pkg::ptr_type'(p + 1'b1);
   endfunction

   function automatic logic store_is_empty();
      return fill[tcpq_pkg::CLS_HIGH] == '0 && fill[tcpq_pkg::CLS_MID] == '0 &&
             fill[tcpq_pkg::CLS_LOW] == '0;
   endfunction

   function automatic outcome_type queue_outcome(tcpq_pkg::action_type act,
                                                 logic [tcpq_pkg::TYPE_W-1:0] etype,
                                                 logic [tcpq_pkg::HANDLE_W-1:0] handle);
      outcome_type       o;
      tcpq_pkg::cls_type c;
      o = '0;
      unique case (act)
         tcpq_pkg::ACT_PUSH: begin
            c = (etype == tcpq_pkg::TYPE_LOW) ? tcpq_pkg::CLS_LOW :
                (etype == tcpq_pkg::TYPE_MID) ? tcpq_pkg::CLS_MID : tcpq_pkg::CLS_HIGH;
            o.cls = c;
            if (fill[c] == tcpq_pkg::cnt_type'(tcpq_pkg::CLASS_DEPTH)) begin
               o.full_drop = 1'b1;
            end else begin
               slot[c][wr_ptr[c]] = tcpq_pkg::data_type'(handle);
               wr_ptr[c] = next_slot(wr_ptr[c]);
               fill[c] = fill[c] + 1'b1;
            end
         end
         tcpq_pkg::ACT_POP, tcpq_pkg::ACT_PEEK: begin
            if (store_is_empty()) begin
               o.empty_error = 1'b1;
            end else begin
               c = (fill[tcpq_pkg::CLS_HIGH] != '0) ? tcpq_pkg::CLS_HIGH :
                   (fill[tcpq_pkg::CLS_MID] != '0) ? tcpq_pkg::CLS_MID : tcpq_pkg::CLS_LOW;
               o.handle = tcpq_pkg::HANDLE_W'(slot[c][rd_ptr[c]]);
               o.cls = c;
               if (act == tcpq_pkg::ACT_POP) begin
                  rd_ptr[c] = next_slot(rd_ptr[c]);
                  fill[c] = fill[c] - 1'b1;
               end
            end
         end
         default: ;
      endcase
      o.now_empty = store_is_empty();
      return o;
   endfunction

   task automatic check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < tcpq_pkg::NUM_CLASSES; i++) begin
            rd_ptr[i] = '0;
            wr_ptr[i] = '0;
            fill[i] = '0;
         end
         pend_rd = '0;
         pend_wr = '0;
         pend_count = 0;
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (pend_count == 0) begin
               $display("%0t: response word with none expected, actual handle %0h class %0d",
                        $time, rsp_out_handle, rsp_out_class);
               fail_count++;
            end else begin
               want = pending[pend_rd];
               pend_rd = pend_rd + 1'b1;
               pend_count--;
               check_field("out_handle", want.handle, rsp_out_handle);
               check_field("out_class", want.cls, rsp_out_class);
               check_field("empty_error", want.empty_error, rsp_empty_error);
               check_field("full_drop", want.full_drop, rsp_full_drop);
               check_field("now_empty", want.now_empty, rsp_now_empty);
            end
         end
         if (start && !busy) begin
            if (pend_count == PEND_DEPTH) begin
               $display("%0t: too many words in flight, expected at most %0d, actual %0d",
                        $time, PEND_DEPTH, pend_count + 1);
               fail_count++;
            end else begin
               pending[pend_wr] = queue_outcome(req_action, req_entry_type,
                                                req_entry_handle);
               pend_wr = pend_wr + 1'b1;
               pend_count++;
            end
         end
      end
      outstanding = pend_count;
   end

endmodule

// File: verif/three_class_priority_queue_unit_tb.sv
// Testbench top that drives the three-class priority queue and reports the verdict.
module three_class_priority_queue_unit_tb;

   localparam tcpq_pkg::action_type ACT_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 425;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   tcpq_pkg::action_type          req_action = tcpq_pkg::ACT_PUSH;
   logic [tcpq_pkg::TYPE_W-1:0]   req_entry_type = '0;
   logic [tcpq_pkg::HANDLE_W-1:0] req_entry_handle = '0;
   logic                          busy;
   logic                          rsp_strobe;
   logic [tcpq_pkg::HANDLE_W-1:0] rsp_out_handle;
   logic [tcpq_pkg::CLASS_W-1:0]  rsp_out_class;
   logic                          rsp_empty_error;
   logic                          rsp_full_drop;
   logic                          rsp_now_empty;
   int                            fail_count;
   int                            outstanding;
   logic                          accept_seen = 1'b0;
   int                            idle_pct = 0;
   int                            quiet_cycles = 0;
   int                            idle_plan [4] = '{0, 66, 17, 0};

   always #1 clock = ~clock;

   three_class_priority_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_entry_type   (req_entry_type),
      .req_entry_handle (req_entry_handle),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_out_class    (rsp_out_class),
      .rsp_empty_error  (rsp_empty_error),
      .rsp_full_drop    (rsp_full_drop),
      .rsp_now_empty    (rsp_now_empty)
   );

   tcpq_checker outcome_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_entry_type   (req_entry_type),
      .req_entry_handle (req_entry_handle),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_out_class    (rsp_out_class),
      .rsp_empty_error  (rsp_empty_error),
      .rsp_full_drop    (rsp_full_drop),
      .rsp_now_empty    (rsp_now_empty),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      accept_seen <= start && !busy && !reset;
      if ((start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(tcpq_pkg::action_type act, logic [tcpq_pkg::TYPE_W-1:0] etype,
                            logic [tcpq_pkg::HANDLE_W-1:0] handle);
      while (int'($urandom_range(99)) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_entry_type <= etype;
      req_entry_handle <= handle;
      @(negedge clock);
      while (!accept_seen) @(negedge clock);
   endtask

   function automatic logic [tcpq_pkg::TYPE_W-1:0] pick_type();
      case ($urandom_range(3))
         0: return tcpq_pkg::TYPE_LOW;
         1: return tcpq_pkg::TYPE_MID;
         default: return tcpq_pkg::TYPE_W'($urandom_range(255));
      endcase
   endfunction

   function automatic tcpq_pkg::action_type pick_action();
      int r;
      r = $urandom_range(19);
      if (r < 9) return tcpq_pkg::ACT_PUSH;
      if (r < 15) return tcpq_pkg::ACT_POP;
      if (r < 19) return tcpq_pkg::ACT_PEEK;
      return ACT_UNUSED;
   endfunction

   initial begin
      int                          burst;
      int                          mode;
      int                          phase_items;
      logic [tcpq_pkg::TYPE_W-1:0] fill_type;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_word(tcpq_pkg::ACT_PEEK, 8'hFF, 16'hFFFF);
      send_word(tcpq_pkg::ACT_POP, 8'h00, 16'h0000);
      send_word(ACT_UNUSED, 8'hFF, 16'hFFFF);
      send_word(tcpq_pkg::ACT_PUSH, tcpq_pkg::TYPE_LOW, 16'h0000);
      send_word(tcpq_pkg::ACT_PUSH, 8'hFF, 16'h5A5A);
      // The seventeenth push to the middle class must be dropped.
      for (int i = 0; i <= tcpq_pkg::CLASS_DEPTH; i++) begin
         send_word(tcpq_pkg::ACT_PUSH, tcpq_pkg::TYPE_MID,
                   tcpq_pkg::HANDLE_W'(i * 16'h1111));
      end
      send_word(tcpq_pkg::ACT_PEEK, 8'h00, 16'h0000);
      send_word(tcpq_pkg::ACT_POP, 8'h00, 16'h0000);
      send_word(tcpq_pkg::ACT_POP, 8'h00, 16'h0000);

      foreach (idle_plan[p]) begin
         idle_pct = idle_plan[p];
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            mode = $urandom_range(9);
            if (mode < 5) begin
               burst = $urandom_range(1, 40);
               repeat (burst) begin
                  send_word(pick_action(), pick_type(), tcpq_pkg::HANDLE_W'($urandom()));
               end
            end else if (mode < 7) begin
               burst = $urandom_range(4, 20);
               fill_type = pick_type();
               repeat (burst) begin
                  send_word(tcpq_pkg::ACT_PUSH, fill_type, tcpq_pkg::HANDLE_W'($urandom()));
               end
            end else begin
               burst = $urandom_range(4, 52);
               repeat (burst) begin
                  send_word(($urandom_range(3) == 0) ? tcpq_pkg::ACT_PEEK : tcpq_pkg::ACT_POP,
                            pick_type(), tcpq_pkg::HANDLE_W'($urandom()));
               end
            end
            phase_items += burst;
         end
      end

      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
